@@ rtl/core/char_lcd_nibble_bus_controller_defines.svh @@
// Assertion macros shared by the checker of the character LCD controller.
// No dependencies; included by bare file name where assertions are written.
`ifndef CHAR_LCD_NIBBLE_BUS_CONTROLLER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_BUS_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define CLCD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, quiet during reset.
`define CLCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/clcd_pkg.sv @@
// Types, codes and lookup functions for the character LCD controller.
// No dependencies; imported by the sequencer and the top level.
package clcd_pkg;

    localparam int PULSE_W  = 8;
    localparam int SETTLE_W = 16;
    localparam int CFG_W    = 16;

    localparam logic [PULSE_W-1:0]  PULSE_RESET  = 8'd4;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic CFG_PULSE  = 1'b0;
    localparam logic CFG_SETTLE = 1'b1;

    // Request opcodes.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_INSTR  = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;
    localparam logic [1:0] OP_CURSOR = 2'd3;

    // Position in the power-up instruction list.
    localparam logic [2:0] INIT_LAST  = 3'd4;
    localparam logic [2:0] INIT_FINAL = 3'd5;
    localparam logic [2:0] INIT_DONE  = 3'd7;

    localparam logic [7:0] SET_DDRAM = 8'b1000_0000;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic [1:0] row;
        logic       busy_sample;
    } in_item_t;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_rw;
        logic       pin_enable;
        logic [3:0] pin_nibble;
        logic       drive_data;
        logic       ready_res;
    } out_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0]  pulse_ticks;
        logic [SETTLE_W-1:0] settle_ticks;
    } cfg_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h06;
            default: b = 8'h02;
        endcase
        return b;
    endfunction

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] b;
        case (row)
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h14;
            2'd3:    b = 7'h54;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/clcd_seq.sv @@
// Pin sequencer of the character LCD controller: phase register, tick counter
// and the held byte, advanced once per accepted word. Depends on clcd_pkg.
module clcd_seq
    import clcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam logic [4:0] PH_POWER  = 5'd0;
    localparam logic [4:0] PH_IH1    = 5'd1;
    localparam logic [4:0] PH_IL1    = 5'd2;
    localparam logic [4:0] PH_GAP1   = 5'd3;
    localparam logic [4:0] PH_IH2    = 5'd4;
    localparam logic [4:0] PH_IL2    = 5'd5;
    localparam logic [4:0] PH_GAP2   = 5'd6;
    localparam logic [4:0] PH_SETTLE = 5'd7;
    localparam logic [4:0] PH_QH1    = 5'd8;
    localparam logic [4:0] PH_QL1    = 5'd9;
    localparam logic [4:0] PH_QH2    = 5'd10;
    localparam logic [4:0] PH_QL2    = 5'd11;
    localparam logic [4:0] PH_WH1    = 5'd12;
    localparam logic [4:0] PH_WL1    = 5'd13;
    localparam logic [4:0] PH_WH2    = 5'd14;
    localparam logic [4:0] PH_WL2    = 5'd15;
    localparam logic [4:0] PH_IDLE   = 5'd16;

    logic [4:0]          phase_reg, phase_next;
    logic [7:0]          held_byte_reg, held_byte_next;
    logic                held_select_reg, held_select_next;
    logic [SETTLE_W-1:0] wait_reg, wait_next;
    logic [2:0]          init_reg, init_next;
    logic                busy_reg, busy_next;

    // State after recovery from a bad code and after skipping zero-length waits.
    logic [4:0]          ph;
    logic [7:0]          hb;
    logic                hs;
    logic [SETTLE_W-1:0] wc;
    logic [2:0]          ini;
    logic                settle_kind;
    logic [SETTLE_W-1:0] len;
    logic [SETTLE_W:0]   wc_inc;
    logic [6:0]          cursor_addr;

    always_comb begin
        ph  = phase_reg;
        hb  = held_byte_reg;
        hs  = held_select_reg;
        wc  = wait_reg;
        ini = init_reg;
        if (ph > PH_IDLE) begin
            ph  = PH_IDLE;
            ini = INIT_DONE;
            wc  = '0;
        end
        // With no settle time every wait is passed over in the same tick; the
        // chain is at most the second init gap followed by the settle wait.
        if (cfg.settle_ticks == '0) begin
            case (ph)
                PH_POWER: begin
                    ph = PH_IH1;
                    wc = '0;
                end
                PH_GAP1: begin
                    ph = PH_IH2;
                    wc = '0;
                end
                PH_GAP2: begin
                    ph  = PH_QH1;
                    ini = '0;
                    hb  = init_byte('0);
                    hs  = 1'b0;
                    wc  = '0;
                end
                PH_SETTLE: begin
                    ph = PH_QH1;
                    wc = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        result = '0;
        if (ph <= PH_GAP2) begin
            result.drive_data = 1'b1;
            result.pin_enable = (ph == PH_IH1) || (ph == PH_IH2);
        end else if (ph >= PH_QH1 && ph <= PH_QL2) begin
            result.pin_rw     = 1'b1;
            result.pin_enable = (ph == PH_QH1) || (ph == PH_QH2);
        end else if (ph >= PH_WH1 && ph <= PH_WL2) begin
            result.pin_rs     = hs;
            result.drive_data = 1'b1;
            result.pin_enable = (ph == PH_WH1) || (ph == PH_WH2);
            result.pin_nibble = (ph <= PH_WL1) ? hb[7:4] : hb[3:0];
        end else if (ph == PH_IDLE) begin
            result.ready_res = 1'b1;
        end
    end

    assign settle_kind = (ph == PH_POWER) || (ph == PH_GAP1) || (ph == PH_GAP2)
                         || (ph == PH_SETTLE);
    assign len = settle_kind ? cfg.settle_ticks
               : (cfg.pulse_ticks == '0) ? SETTLE_W'(1) : SETTLE_W'(cfg.pulse_ticks);
    assign wc_inc      = {1'b0, wc} + (SETTLE_W+1)'(1);
    assign cursor_addr = row_base(item.row) + 7'(item.column);

    always_comb begin
        phase_next       = ph;
        held_byte_next   = hb;
        held_select_next = hs;
        wait_next        = wc;
        init_next        = ini;
        busy_next        = busy_reg;
        if (ph == PH_IDLE) begin
            case (item.opcode)
                OP_INSTR, OP_DATA: begin
                    held_byte_next   = item.byte_value;
                    held_select_next = (item.opcode == OP_DATA);
                    phase_next       = PH_SETTLE;
                    wait_next        = '0;
                end
                OP_CURSOR: begin
                    held_byte_next   = SET_DDRAM | {1'b0, cursor_addr};
                    held_select_next = 1'b0;
                    phase_next       = PH_SETTLE;
                    wait_next        = '0;
                end
                default: ;
            endcase
        end else begin
            // Only the first nibble of a poll carries the busy flag.
            if (ph == PH_QH1) begin
                busy_next = item.busy_sample;
            end
            if (wc_inc >= {1'b0, len}) begin
                wait_next = '0;
                case (ph)
                    PH_GAP2: begin
                        init_next        = '0;
                        held_byte_next   = init_byte('0);
                        held_select_next = 1'b0;
                        phase_next       = PH_SETTLE;
                    end
                    PH_QL2: begin
                        if (busy_next) begin
                            phase_next = PH_QH1;
                        end else if (ini == INIT_FINAL) begin
                            init_next  = INIT_DONE;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_WH1;
                        end
                    end
                    PH_WL2: begin
                        if (ini < INIT_LAST) begin
                            init_next        = ini + 3'd1;
                            held_byte_next   = init_byte(ini + 3'd1);
                            held_select_next = 1'b0;
                            phase_next       = PH_SETTLE;
                        end else if (ini == INIT_LAST) begin
                            init_next  = INIT_FINAL;
                            phase_next = PH_SETTLE;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: phase_next = ph + 5'd1;
                endcase
            end else begin
                wait_next = wc_inc[SETTLE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_POWER;
            held_byte_reg   <= '0;
            held_select_reg <= 1'b0;
            wait_reg        <= '0;
            init_reg        <= '0;
            busy_reg        <= 1'b1;
        end else if (step) begin
            phase_reg       <= phase_next;
            held_byte_reg   <= held_byte_next;
            held_select_reg <= held_select_next;
            wait_reg        <= wait_next;
            init_reg        <= init_next;
            busy_reg        <= busy_next;
        end
    end

endmodule

@@ rtl/core/char_lcd_nibble_bus_controller.sv @@
// Character LCD controller on a 4-bit bus: input word per clock tick of the
// display sequencer, one result word of pin levels per input word.
// Usage:
//   s_valid/s_ready/s_data carry one tick word: opcode, byte, column, row and
//   the level sampled on data line 7. m_valid/m_ready/m_data carry the pin
//   levels (RS, RW, E, data nibble, drive enable) and the idle flag.
//   The cfg_wr_* port writes pulse_ticks (index 0) and settle_ticks
//   (index 1) with no handshake; write only while idle.
//   Throughput is one word per cycle unless the receiver stalls; the sequencer
//   state is updated by a single pass of logic in the cycle a word is taken.
//   Its result leaves the result register to the m_ side in the next cycle.
//   If the receiver stalls, the held result stays on m_data and s_ready drops
//   only while the result register is full and not being emptied.
//   Synchronous active-low reset returns to the power-up wait, empties the
//   result register and restores pulse_ticks to 4 and settle_ticks to 1000.
//   After reset the block runs its power-up wait, two bare enable pulses and
//   five init instructions, driven by incoming tick words; ready_res then
//   rises and a request is taken on a word with a nonzero opcode.
// Depends on clcd_pkg and clcd_seq.
module char_lcd_nibble_bus_controller
    import clcd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_index,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    logic      m_valid_reg;
    out_item_t m_data_reg;
    cfg_t      cfg_reg;
    out_item_t result;
    logic      step;

    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    clcd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (s_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ticks  <= PULSE_RESET;
            cfg_reg.settle_ticks <= SETTLE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_PULSE:  cfg_reg.pulse_ticks  <= cfg_wr_data[PULSE_W-1:0];
                CFG_SETTLE: cfg_reg.settle_ticks <= cfg_wr_data[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= result;
        end
    end

endmodule

@@ rtl/core/clcd_checker.sv @@
// Port-level assertions for the character LCD controller, bound to the top.
// Depends on clcd_pkg and char_lcd_nibble_bus_controller_defines.svh.
`include "char_lcd_nibble_bus_controller_defines.svh"

module clcd_checker
    import clcd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic idle_quiet;
    logic released_zero;

    assign idle_quiet = !m_data.pin_rs && !m_data.pin_rw && !m_data.pin_enable
                        && !m_data.drive_data && (m_data.pin_nibble == '0);
    assign released_zero = m_data.drive_data || (m_data.pin_nibble == '0);

    // A stalled result word must be held.
    `CLCD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")
    // An empty result register always takes the next word.
    `CLCD_ASSERT_NOW(a_empty_ready, aclk, aresetn, !m_valid, s_ready, "input refused with empty result register")
    // Idle words leave every line low and released.
    `CLCD_ASSERT_NOW(a_idle_quiet, aclk, aresetn, m_valid && m_data.ready_res, idle_quiet, "pins active in an idle word")
    // Released data lines show zero.
    `CLCD_ASSERT_NOW(a_released_zero, aclk, aresetn, m_valid, released_zero, "nibble nonzero with lines released")
    // Busy polling reads the bus, so the lines are never driven with RW high.
    `CLCD_ASSERT_NOW(a_poll_released, aclk, aresetn, m_valid && m_data.pin_rw, !m_data.drive_data && !m_data.pin_rs, "lines driven while reading")

endmodule

bind char_lcd_nibble_bus_controller clcd_checker u_clcd_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for the character LCD nibble bus controller.
// Depends on clcd_pkg and the controller RTL; it predicts every pin word in the
// testbench and compares each one as it leaves the block.
module testbench;
    import clcd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 250_000;

    typedef enum logic [4:0] {
        SQ_POWER_WAIT, SQ_INIT_HI1, SQ_INIT_LO1, SQ_INIT_GAP1, SQ_INIT_HI2, SQ_INIT_LO2,
        SQ_INIT_GAP2, SQ_SETTLE, SQ_POLL_HI1, SQ_POLL_LO1, SQ_POLL_HI2, SQ_POLL_LO2,
        SQ_WR_HI1, SQ_WR_LO1, SQ_WR_HI2, SQ_WR_LO2, SQ_IDLE
    } seq_step_e;

    class lcd_scoreboard;
        logic [7:0]  pulse_len;
        logic [15:0] settle_len;
        seq_step_e   step;
        logic [7:0]  held_byte;
        logic        held_rs;
        int unsigned tick_count;
        logic [2:0]  init_step;
        logic        busy_flag;
        logic [7:0]  boot_bytes [5];
        logic [6:0]  row_offsets [4];
        out_item_t   pending [$];
        int unsigned fail_count;
        int unsigned checked;
        int unsigned poll_repeats;
        int unsigned req_count [4];

        function new();
            boot_bytes  = '{8'h02, 8'h28, 8'h01, 8'h0C, 8'h06};
            row_offsets = '{7'h00, 7'h40, 7'h14, 7'h54};
            pulse_len   = PULSE_RESET;
            settle_len  = SETTLE_RESET;
            step        = SQ_POWER_WAIT;
            held_byte   = '0;
            held_rs     = 1'b0;
            tick_count  = 0;
            init_step   = '0;
            busy_flag   = 1'b1;
            fail_count  = 0;
            checked     = 0;
            poll_repeats = 0;
            req_count   = '{0, 0, 0, 0};
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_PULSE)
                pulse_len = value[7:0];
            else
                settle_len = value[15:0];
        endfunction

        function bit idle();
            return step == SQ_IDLE;
        endfunction

        function bit is_wait(seq_step_e s);
            return s inside {SQ_POWER_WAIT, SQ_INIT_GAP1, SQ_INIT_GAP2, SQ_SETTLE};
        endfunction

        function int unsigned step_ticks(seq_step_e s);
            if (is_wait(s))
                return settle_len;
            return (pulse_len == 0) ? 1 : pulse_len;
        endfunction

        function void load_boot_byte();
            held_byte = boot_bytes[(init_step < 3'd5) ? init_step : 3'd0];
            held_rs   = 1'b0;
        endfunction

        function void next_step();
            tick_count = 0;
            case (step)
                SQ_INIT_GAP2: begin
                    init_step = '0;
                    load_boot_byte();
                    step = SQ_SETTLE;
                end
                SQ_POLL_LO2: begin
                    if (busy_flag) begin
                        step = SQ_POLL_HI1;
                        poll_repeats++;
                    end else if (init_step == INIT_FINAL) begin
                        init_step = INIT_DONE;
                        step = SQ_IDLE;
                    end else begin
                        step = SQ_WR_HI1;
                    end
                end
                SQ_WR_LO2: begin
                    if (init_step < INIT_LAST) begin
                        init_step++;
                        load_boot_byte();
                        step = SQ_SETTLE;
                    end else if (init_step == INIT_LAST) begin
                        init_step = INIT_FINAL;
                        step = SQ_SETTLE;
                    end else begin
                        step = SQ_IDLE;
                    end
                end
                SQ_IDLE: step = SQ_IDLE;
                default: step = seq_step_e'(step + 1);
            endcase
        endfunction

        // Works out the pin word for one tick and moves the sequencer on.
        function void note_input(in_item_t w);
            out_item_t  r;
            logic [7:0] addr_sum;
            r = '0;
            // A zero settle time skips every wait it would set.
            while (is_wait(step) && settle_len == 0)
                next_step();

            if (step <= SQ_INIT_GAP2) begin
                r.drive_data = 1'b1;
                r.pin_enable = (step == SQ_INIT_HI1 || step == SQ_INIT_HI2);
            end else if (step >= SQ_POLL_HI1 && step <= SQ_POLL_LO2) begin
                r.pin_rw     = 1'b1;
                r.pin_enable = (step == SQ_POLL_HI1 || step == SQ_POLL_HI2);
            end else if (step >= SQ_WR_HI1 && step <= SQ_WR_LO2) begin
                r.pin_rs     = held_rs;
                r.drive_data = 1'b1;
                r.pin_enable = (step == SQ_WR_HI1 || step == SQ_WR_HI2);
                r.pin_nibble = (step <= SQ_WR_LO1) ? held_byte[7:4] : held_byte[3:0];
            end else if (step == SQ_IDLE) begin
                r.ready_res = 1'b1;
            end

            if (step == SQ_IDLE) begin
                case (w.opcode)
                    OP_INSTR, OP_DATA: begin
                        held_byte  = w.byte_value;
                        held_rs    = (w.opcode == OP_DATA);
                        step       = SQ_SETTLE;
                        tick_count = 0;
                        req_count[w.opcode]++;
                    end
                    OP_CURSOR: begin
                        addr_sum   = {1'b0, row_offsets[w.row]} + {2'b00, w.column};
                        held_byte  = SET_DDRAM | {1'b0, addr_sum[6:0]};
                        held_rs    = 1'b0;
                        step       = SQ_SETTLE;
                        tick_count = 0;
                        req_count[w.opcode]++;
                    end
                    default: ;
                endcase
            end else begin
                // Only the first nibble of a poll carries the busy flag.
                if (step == SQ_POLL_HI1)
                    busy_flag = w.busy_sample;
                tick_count = (tick_count + 1) & 32'h000F_FFFF;
                if (tick_count >= step_ticks(step))
                    next_step();
            end
            pending.push_back(r);
        endfunction

        function string pin_text(out_item_t p);
            return $sformatf("rs=%b rw=%b e=%b nib=%h drv=%b rdy=%b", p.pin_rs, p.pin_rw,
                             p.pin_enable, p.pin_nibble, p.drive_data, p.ready_res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected result word %s", pin_text(got));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.pin_rs !== want.pin_rs || got.pin_rw !== want.pin_rw ||
                got.pin_enable !== want.pin_enable || got.pin_nibble !== want.pin_nibble ||
                got.drive_data !== want.drive_data || got.ready_res !== want.ready_res) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: word %0d expected %s, got %s", checked,
                             pin_text(want), pin_text(got));
            end
        endfunction
    endclass

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    in_item_t         s_data       = '0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    out_item_t        m_data;
    logic             cfg_wr_en    = 1'b0;
    logic             cfg_wr_index = CFG_PULSE;
    logic [CFG_W-1:0] cfg_wr_data  = '0;

    bit               idle_enable  = 1'b1;
    int unsigned      stall_left   = 0;
    int unsigned      cycle_count  = 0;
    int unsigned      settings_run = 1;
    in_item_t         directed_q [$];
    lcd_scoreboard    sb;

    always #5 aclk = ~aclk;

    char_lcd_nibble_bus_controller u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // Receiver: checks every accepted word and stalls in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (aresetn && idle_enable && $urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles, %0d words still expected",
                     cycle_count, sb.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic in_item_t request_word(logic [1:0] op, logic [7:0] value,
                                              logic [5:0] col, logic [1:0] row_sel);
        in_item_t w;
        w.opcode      = op;
        w.byte_value  = value;
        w.column      = col;
        w.row         = row_sel;
        w.busy_sample = 1'b0;
        return w;
    endfunction

    task automatic send_word(input in_item_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_input(w);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    // Feeds tick words until the given number of requests has been taken, the
    // directed list is empty and the sequencer is back in idle.
    task automatic run_phase(input int unsigned n_req);
        int unsigned taken;
        in_item_t    w;
        bit          is_req;
        taken = 0;
        while (taken < n_req || directed_q.size() != 0 || !sb.idle()) begin
            w.opcode      = OP_TICK;
            w.byte_value  = 8'($urandom);
            w.row         = 2'($urandom);
            w.column      = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(40, 63))
                                                        : 6'($urandom_range(0, 39));
            w.busy_sample = ($urandom_range(0, 9) < 3);
            is_req = 1'b0;
            if (sb.idle()) begin
                if (directed_q.size() != 0) begin
                    w = directed_q.pop_front();
                    is_req = 1'b1;
                end else if (taken < n_req && $urandom_range(0, 3) != 0) begin
                    w.opcode = 2'($urandom_range(1, 3));
                    is_req = 1'b1;
                end
            end else if ($urandom_range(0, 7) == 0) begin
                // A request while the sequencer is busy must be ignored.
                w.opcode = 2'($urandom_range(1, 3));
            end
            send_word(w);
            if (is_req)
                taken++;
            if (idle_enable && $urandom_range(0, 15) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int unsigned pulse_tab  [4];
        int unsigned settle_tab [4];
        int unsigned req_tab    [4];
        bit          idle_tab   [4];

        pulse_tab  = '{1, 0, 3, 2};
        settle_tab = '{0, 1, 2, 4};
        req_tab    = '{30, 12, 3, 8};
        idle_tab   = '{1, 1, 1, 0};

        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Power-up at the reset pulse width with every wait skipped.
        write_reg(CFG_SETTLE, 16'd0);
        cfg_wr_en <= 1'b0;
        run_phase(0);

        // Directed requests at the shortest pulse width.
        write_reg(CFG_PULSE, {8'($urandom), 8'd1});
        cfg_wr_en <= 1'b0;
        settings_run++;
        directed_q = '{
            request_word(OP_INSTR,  8'h00, 6'd0,  2'd0),
            request_word(OP_INSTR,  8'hFF, 6'd0,  2'd0),
            request_word(OP_INSTR,  8'h01, 6'd63, 2'd3),
            request_word(OP_DATA,   8'h00, 6'd0,  2'd0),
            request_word(OP_DATA,   8'hFF, 6'd63, 2'd3),
            request_word(OP_DATA,   8'hA5, 6'd0,  2'd0),
            request_word(OP_DATA,   8'h5A, 6'd0,  2'd0),
            request_word(OP_CURSOR, 8'h00, 6'd0,  2'd0),
            request_word(OP_CURSOR, 8'hFF, 6'd39, 2'd1),
            request_word(OP_CURSOR, 8'h00, 6'd20, 2'd2),
            request_word(OP_CURSOR, 8'h00, 6'd39, 2'd3),
            request_word(OP_CURSOR, 8'h00, 6'd63, 2'd3),
            request_word(OP_CURSOR, 8'h00, 6'd63, 2'd1),
            request_word(OP_CURSOR, 8'h00, 6'd40, 2'd0)
        };
        run_phase(0);

        for (int i = 0; i < 4; i++) begin
            write_reg(CFG_PULSE, {8'($urandom), 8'(pulse_tab[i])});
            write_reg(CFG_SETTLE, 16'(settle_tab[i]));
            cfg_wr_en <= 1'b0;
            idle_enable = idle_tab[i];
            settings_run++;
            run_phase(req_tab[i]);
        end

        repeat (10) @(posedge aclk);
        $display("Covered %0d instruction, %0d data and %0d cursor requests; %0d words checked.",
                 sb.req_count[OP_INSTR], sb.req_count[OP_DATA], sb.req_count[OP_CURSOR],
                 sb.checked);
        $display("Busy polls repeated %0d times over %0d register settings; %0d mismatches.",
                 sb.poll_repeats, settings_run, sb.fail_count);
        if (sb.fail_count == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
